// ----- design/token_grammar_mask_tracker_unit_assert.svh -----
// Assertion macros for the token grammar mask tracker.
`ifndef TOKEN_GRAMMAR_MASK_TRACKER_UNIT_ASSERT_SVH
`define TOKEN_GRAMMAR_MASK_TRACKER_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define TGMT_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define TGMT_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/tgmt_pkg.sv -----
// Types, constants and the next-kind mask function of the grammar tracker.
package tgmt_pkg;

    localparam int KIND_W  = 4;
    localparam int MASK_W  = 10;
    localparam int LIMIT_W = 4;
    localparam int COUNT_W = 4;
    localparam int EVENT_W = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
    localparam logic [EVENT_W-1:0] EVENT_MAX   = {EVENT_W{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_END       = 4'd0,
        KIND_SHIFT     = 4'd1,
        KIND_TIME      = 4'd2,
        KIND_METER     = 4'd3,
        KIND_EIGHTH    = 4'd4,
        KIND_STRUCTURE = 4'd5,
        KIND_KEY       = 4'd6,
        KIND_CHORD     = 4'd7,
        KIND_PITCH     = 4'd8,
        KIND_DURATION  = 4'd9
    } kind_t;

    typedef enum logic [2:0] {
        FIELD_NONE      = 3'd0,
        FIELD_TIME      = 3'd1,
        FIELD_RHYTHM    = 3'd2,
        FIELD_STRUCTURE = 3'd3,
        FIELD_KEY       = 3'd4,
        FIELD_CHORD     = 3'd5,
        FIELD_MELODY    = 3'd6
    } field_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_METER = 2'd1,
        PEND_PITCH = 2'd2
    } pend_t;

    // Kinds that may follow, from the state after the update.
    function automatic logic [MASK_W-1:0] grammar_mask(
        input field_t             last_field,
        input pend_t              pending,
        input logic               shifting,
        input logic [COUNT_W-1:0] shift_count,
        input logic               has_payload,
        input logic [LIMIT_W-1:0] limit
    );
        logic [MASK_W-1:0] m;
        m = '0;
        m[KIND_END]   = has_payload;
        m[KIND_SHIFT] = (has_payload || shifting) && (shift_count < limit);
        case (pending)
            PEND_METER:
            begin
                m[KIND_EIGHTH] = 1'b1;
            end
            PEND_PITCH:
            begin
                m[KIND_DURATION] = 1'b1;
                m[KIND_PITCH]    = 1'b1;
            end
            default:
            begin
                m[KIND_TIME]      = (last_field < FIELD_TIME);
                m[KIND_METER]     = (last_field < FIELD_RHYTHM);
                m[KIND_EIGHTH]    = (last_field < FIELD_RHYTHM);
                m[KIND_STRUCTURE] = (last_field < FIELD_STRUCTURE);
                m[KIND_KEY]       = (last_field < FIELD_KEY);
                m[KIND_CHORD]     = (last_field < FIELD_CHORD);
                m[KIND_PITCH]     = 1'b1;
            end
        endcase
        return m;
    endfunction

endpackage

// ----- design/tgmt_token_if.sv -----
// Input channel: one token kind per word.
interface tgmt_token_if;
    import tgmt_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] token_kind;

    modport source (output valid, output token_kind, input ready);
    modport sink (input valid, input token_kind, output ready);
endinterface

// ----- design/tgmt_result_if.sv -----
// Output channel: allowed-kind mask and status per word.
interface tgmt_result_if;
    import tgmt_pkg::*;

    logic               valid;
    logic               ready;
    logic [MASK_W-1:0]  allowed_kinds;
    logic               ended;
    logic               bad_token;
    logic [EVENT_W-1:0] event_count;

    modport source (output valid, output allowed_kinds, output ended, output bad_token,
                    output event_count, input ready);
    modport sink (input valid, input allowed_kinds, input ended, input bad_token,
                  input event_count, output ready);
endinterface

// ----- design/token_grammar_mask_tracker_unit.sv -----
// A token moves into the input reg, then into the result reg, where its result word is shown.
// One token per cycle unless results stall; state updates as a word moves into the result reg.
// The input stage keeps taking tokens while a result waits, up to one held word.
// Reset (rst_n low, async) clears grammar state, event count and valids; shift limit goes to 4.
// Write the shift limit via cfg_wen / cfg_wdata only while idle; the unit does not enforce it.
module token_grammar_mask_tracker_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wen,
    input  logic [tgmt_pkg::LIMIT_W-1:0]  cfg_wdata,
    tgmt_token_if.sink                    tokens,
    tgmt_result_if.source                 results
);
    import tgmt_pkg::*;

    `include "token_grammar_mask_tracker_unit_assert.svh"

    logic [LIMIT_W-1:0] shift_limit_reg;

    logic              s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    logic              out_valid_reg;
    logic              advance;

    field_t             last_field_reg, last_field_next;
    pend_t              pending_reg, pending_next;
    logic               shifting_reg, shifting_next;
    logic [COUNT_W-1:0] shift_count_reg, shift_count_next;
    logic               has_payload_reg, has_payload_next;
    logic [EVENT_W-1:0] events_reg, events_next;

    logic [MASK_W-1:0]  mask_reg;
    logic               ended_reg, ended_next;
    logic               bad_reg, bad_next;

    assign advance      = s1_valid_reg && (!out_valid_reg || results.ready);
    assign tokens.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shift_limit_reg <= LIMIT_RESET;
        else if (cfg_wen)
            shift_limit_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (tokens.valid && tokens.ready)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tokens.valid && tokens.ready)
            s1_kind_reg <= tokens.token_kind;
    end

    always_comb
    begin
        last_field_next  = last_field_reg;
        pending_next     = pending_reg;
        shifting_next    = shifting_reg;
        shift_count_next = shift_count_reg;
        has_payload_next = has_payload_reg;
        events_next      = events_reg;
        ended_next       = 1'b0;
        bad_next         = 1'b0;
        case (kind_t'(s1_kind_reg))
            KIND_END:
            begin
                ended_next = 1'b1;
            end
            KIND_SHIFT:
            begin
                // first shift after a payload closes the event
                if (!shifting_reg && has_payload_reg)
                begin
                    if (events_reg != EVENT_MAX)
                        events_next = events_reg + 1'b1;
                    has_payload_next = 1'b0;
                    last_field_next  = FIELD_NONE;
                    pending_next     = PEND_NONE;
                end
                shifting_next = 1'b1;
                if (shift_count_reg != COUNT_MAX)
                    shift_count_next = shift_count_reg + 1'b1;
            end
            KIND_TIME, KIND_METER, KIND_EIGHTH, KIND_STRUCTURE, KIND_KEY, KIND_CHORD,
            KIND_PITCH, KIND_DURATION:
            begin
                shifting_next    = 1'b0;
                shift_count_next = '0;
                has_payload_next = 1'b1;
                pending_next     = PEND_NONE;
                case (kind_t'(s1_kind_reg))
                    KIND_TIME:      last_field_next = FIELD_TIME;
                    KIND_METER:
                    begin
                        last_field_next = FIELD_RHYTHM;
                        pending_next    = PEND_METER;
                    end
                    KIND_EIGHTH:    last_field_next = FIELD_RHYTHM;
                    KIND_STRUCTURE: last_field_next = FIELD_STRUCTURE;
                    KIND_KEY:       last_field_next = FIELD_KEY;
                    KIND_CHORD:     last_field_next = FIELD_CHORD;
                    KIND_PITCH:
                    begin
                        last_field_next = FIELD_MELODY;
                        pending_next    = PEND_PITCH;
                    end
                    default:        last_field_next = FIELD_MELODY;
                endcase
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_field_reg  <= FIELD_NONE;
            pending_reg     <= PEND_NONE;
            shifting_reg    <= 1'b0;
            shift_count_reg <= '0;
            has_payload_reg <= 1'b0;
            events_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                last_field_reg  <= last_field_next;
                pending_reg     <= pending_next;
                shifting_reg    <= shifting_next;
                shift_count_reg <= shift_count_next;
                has_payload_reg <= has_payload_next;
                events_reg      <= events_next;
                out_valid_reg   <= 1'b1;
            end
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mask_reg  <= grammar_mask(last_field_next, pending_next, shifting_next,
                                      shift_count_next, has_payload_next,
                                      shift_limit_reg);
            ended_reg <= ended_next;
            bad_reg   <= bad_next;
        end
    end

    // event count only moves on a load, so it tracks the held word
    assign results.valid         = out_valid_reg;
    assign results.allowed_kinds = mask_reg;
    assign results.ended         = ended_reg;
    assign results.bad_token     = bad_reg;
    assign results.event_count   = events_reg;

    `TGMT_ASSERT(a_events_monotonic, 1'b1 |=> events_reg >= $past(events_reg), "event count fell")
    `TGMT_ASSERT(a_count_implies_shifting, (shift_count_reg == '0) || shifting_reg, "shift run without shifting")
    `TGMT_ASSERT(a_meter_in_rhythm, pending_reg != PEND_METER || last_field_reg == FIELD_RHYTHM, "meter pending outside rhythm")
    `TGMT_ASSERT(a_bad_keeps_state, advance && bad_next |=> $stable(events_reg) && $stable(last_field_reg) && $stable(shift_count_reg), "unknown kind changed state")

endmodule

// ----- verif/tb_token_grammar_mask_tracker_unit.sv -----
// Self-checking testbench for the token grammar mask tracker unit.
module tb_token_grammar_mask_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tgmt_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN_LO = 4'd10;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN_HI = 4'd15;
    localparam int LATENCY = 2;

    typedef struct {
        logic [MASK_W-1:0]  allowed_kinds;
        logic               ended;
        logic               bad_token;
        logic [EVENT_W-1:0] event_count;
    } grammar_word_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wen;
    logic [LIMIT_W-1:0] cfg_wdata;

    tgmt_token_if  tok ();
    tgmt_result_if res ();

    token_grammar_mask_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .tokens    (tok),
        .results   (res)
    );

    // grammar state as the tracker should hold it
    field_t             reached_field;
    pend_t              owed_part;
    logic               in_shift_run;
    logic [COUNT_W-1:0] shift_run;
    logic               payload_seen;
    logic [EVENT_W-1:0] closed_events;
    logic [LIMIT_W-1:0] run_limit;

    grammar_word_t expected_words[$];
    grammar_word_t oldest_word;
    int            failures     = 0;
    int            src_idle_pct = 0;
    int            snk_stall_pct = 0;
    int            hold_cycles  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [MASK_W-1:0] next_kinds();
        logic [MASK_W-1:0] m;
        m = '0;
        m[KIND_END]   = payload_seen;
        m[KIND_SHIFT] = (payload_seen || in_shift_run) && (shift_run < run_limit);
        if (owed_part == PEND_METER)
        begin
            m[KIND_EIGHTH] = 1'b1;
        end
        else if (owed_part == PEND_PITCH)
        begin
            m[KIND_DURATION] = 1'b1;
            m[KIND_PITCH]    = 1'b1;
        end
        else
        begin
            m[KIND_TIME]      = (reached_field < FIELD_TIME);
            m[KIND_METER]     = (reached_field < FIELD_RHYTHM);
            m[KIND_EIGHTH]    = (reached_field < FIELD_RHYTHM);
            m[KIND_STRUCTURE] = (reached_field < FIELD_STRUCTURE);
            m[KIND_KEY]       = (reached_field < FIELD_KEY);
            m[KIND_CHORD]     = (reached_field < FIELD_CHORD);
            m[KIND_PITCH]     = 1'b1;
        end
        return m;
    endfunction

    // Applies one accepted token to the grammar state and queues its result word.
    task automatic advance_grammar(input logic [KIND_W-1:0] k);
        grammar_word_t w;
        w.ended     = 1'b0;
        w.bad_token = 1'b0;
        case (k)
            KIND_END:
            begin
                w.ended = 1'b1;
            end
            KIND_SHIFT:
            begin
                if (!in_shift_run && payload_seen)
                begin
                    if (closed_events != EVENT_MAX)
                        closed_events = closed_events + 1'b1;
                    payload_seen  = 1'b0;
                    reached_field = FIELD_NONE;
                    owed_part     = PEND_NONE;
                end
                in_shift_run = 1'b1;
                if (shift_run != COUNT_MAX)
                    shift_run = shift_run + 1'b1;
            end
            KIND_TIME, KIND_METER, KIND_EIGHTH, KIND_STRUCTURE, KIND_KEY, KIND_CHORD,
            KIND_PITCH, KIND_DURATION:
            begin
                owed_part = PEND_NONE;
                case (k)
                    KIND_TIME:      reached_field = FIELD_TIME;
                    KIND_METER:
                    begin
                        reached_field = FIELD_RHYTHM;
                        owed_part     = PEND_METER;
                    end
                    KIND_EIGHTH:    reached_field = FIELD_RHYTHM;
                    KIND_STRUCTURE: reached_field = FIELD_STRUCTURE;
                    KIND_KEY:       reached_field = FIELD_KEY;
                    KIND_CHORD:     reached_field = FIELD_CHORD;
                    KIND_PITCH:
                    begin
                        reached_field = FIELD_MELODY;
                        owed_part     = PEND_PITCH;
                    end
                    default:        reached_field = FIELD_MELODY;
                endcase
                in_shift_run = 1'b0;
                shift_run    = '0;
                payload_seen = 1'b1;
            end
            default:
            begin
                w.bad_token = 1'b1;
            end
        endcase
        w.allowed_kinds = next_kinds();
        w.event_count   = closed_events;
        expected_words.push_back(w);
    endtask

    // Mostly a kind the grammar allows next, with shifts favored so events close.
    function automatic logic [KIND_W-1:0] pick_next_kind();
        logic [MASK_W-1:0] m;
        int                pick;
        m = next_kinds();
        if (m[KIND_SHIFT] && ($urandom_range(99) < 20))
            return KIND_SHIFT;
        m[KIND_SHIFT] = 1'b0;
        m[KIND_END]   = m[KIND_END] && ($urandom_range(99) < 5);
        pick = $urandom_range($countones(m) - 1);
        for (int i = 0; i < MASK_W; i++)
        begin
            if (m[i])
            begin
                if (pick == 0)
                    return i[KIND_W-1:0];
                pick--;
            end
        end
        return KIND_PITCH;
    endfunction

    task automatic send_token(input logic [KIND_W-1:0] k);
        while ($urandom_range(99) < src_idle_pct)
        begin
            tok.valid <= 1'b0;
            @(posedge clk);
        end
        tok.valid      <= 1'b1;
        tok.token_kind <= k;
        @(posedge clk);
        while (!tok.ready)
            @(posedge clk);
        advance_grammar(k);
    endtask

    task automatic wait_idle();
        tok.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        run_limit  = v;
    endtask

    task automatic test_directed_event();
        logic [KIND_W-1:0] seq[19];
        seq = '{KIND_END, KIND_SHIFT, KIND_TIME, KIND_METER, KIND_EIGHTH, KIND_STRUCTURE,
                KIND_KEY, KIND_CHORD, KIND_PITCH, KIND_PITCH, KIND_DURATION, KIND_PITCH,
                KIND_END, KIND_SHIFT, KIND_SHIFT, KIND_UNKNOWN_LO, KIND_UNKNOWN_HI,
                KIND_EIGHTH, KIND_SHIFT};
        foreach (seq[i])
            send_token(seq[i]);
        wait_idle();
    endtask

    // Run past the counter's top so the run length saturates.
    task automatic test_long_shift_run();
        write_limit(4'd15);
        send_token(KIND_KEY);
        repeat (18) send_token(KIND_SHIFT);
        send_token(KIND_DURATION);
        wait_idle();
    endtask

    // Receiver holds off long enough for the unit to fill and stall its input.
    task automatic test_backpressure();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_cycles  <= 60;
        repeat (25) send_token(pick_next_kind());
        wait_idle();
        repeat (10) send_token(pick_next_kind());
        wait_idle();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [LIMIT_W-1:0] lim, input int n_tokens);
        write_limit(lim);
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        repeat (n_tokens)
        begin
            if ($urandom_range(99) < 15)
                send_token(KIND_W'($urandom_range(15)));
            else
                send_token(pick_next_kind());
        end
        wait_idle();
    endtask

    // Back-to-back payload and shift pairs, each closing one event.
    task automatic test_event_closing();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        write_limit(LIMIT_RESET);
        repeat (20)
        begin
            send_token(KIND_PITCH);
            send_token(KIND_SHIFT);
        end
        repeat (3)
        begin
            send_token(KIND_CHORD);
            send_token(KIND_SHIFT);
        end
        send_token(KIND_END);
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result word with nothing expected");
                failures++;
            end
            else
            begin
                oldest_word = expected_words.pop_front();
                if (res.allowed_kinds !== oldest_word.allowed_kinds)
                begin
                    $error("allowed_kinds: expected %b, got %b",
                           oldest_word.allowed_kinds, res.allowed_kinds);
                    failures++;
                end
                if (res.ended !== oldest_word.ended)
                begin
                    $error("ended: expected %b, got %b", oldest_word.ended, res.ended);
                    failures++;
                end
                if (res.bad_token !== oldest_word.bad_token)
                begin
                    $error("bad_token: expected %b, got %b",
                           oldest_word.bad_token, res.bad_token);
                    failures++;
                end
                if (res.event_count !== oldest_word.event_count)
                begin
                    $error("event_count: expected %0d, got %0d",
                           oldest_word.event_count, res.event_count);
                    failures++;
                end
            end
        end
        res.ready <= (hold_cycles == 0) && ($urandom_range(99) >= snk_stall_pct);
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_wen        = 1'b0;
        cfg_wdata      = '0;
        tok.valid      = 1'b0;
        tok.token_kind = '0;
        res.ready      = 1'b0;
        reached_field  = FIELD_NONE;
        owed_part      = PEND_NONE;
        in_shift_run   = 1'b0;
        shift_run      = '0;
        payload_seen   = 1'b0;
        closed_events  = '0;
        run_limit      = LIMIT_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_event();
        test_long_shift_run();
        test_backpressure();
        test_random_phase(0, 0, 4'd0, 120);
        test_random_phase(65, 0, 4'd15, 150);
        test_random_phase(0, 65, 4'd1, 150);
        test_random_phase(35, 35, LIMIT_W'($urandom_range(2, 14)), 150);
        test_random_phase(0, 0, 4'd3, 60);
        test_event_closing();

        wait_idle();
        if (failures == 0)
            $display("tb_token_grammar_mask_tracker_unit passed");
        else
            $display("tb_token_grammar_mask_tracker_unit failed");
        $finish;
    end

    initial
    begin
        #200_000;
        $display("tb_token_grammar_mask_tracker_unit failed");
        $finish;
    end

endmodule
